/* sv/mm2h_pkg.sv */
// Shared constants and types for the MurmurHash64A block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mm2h_pkg;

	localparam logic [63:0] MIX_MUL         = 64'hc6a4a7935bd1e995;
	localparam int          MIX_SHIFT       = 47;
	localparam logic [63:0] SEED_RESET      = 64'h00000000ee6b27eb;
	localparam int          LENGTH_BITS_DEF = 32;

	typedef enum logic [2:0] {
		MS_LEN,
		MS_WORD,
		MS_K,
		MS_FOLD,
		MS_FIN
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_start;
		mul_sel_t mul_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic first;
		logic last;
		logic count_full;
		logic count_zero;
		logic out_busy;
	} dp_stat_t;

endpackage

/* sv/mm2h_mul.sv */
// Iterative 64 x 64 multiply by the mix constant, low 64 bits of the product.
// One shared 32 x 32 multiplier, three partial products; uses mm2h_pkg.
`timescale 1ns / 1ps

module mm2h_mul import mm2h_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	output logic        done,
	output logic [63:0] product
);

	typedef enum logic [1:0] {
		ST_LO,
		ST_HI,
		ST_CROSS
	} step_t;

	step_t       step_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] lo_q;
	logic [31:0] cross_q;
	logic [63:0] product_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;

	always_comb begin
		op_a = (step_q == ST_HI) ? a_q[63:32] : a_q[31:0];
		op_b = (step_q == ST_CROSS) ? MIX_MUL[63:32] : MIX_MUL[31:0];
		prod = op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_LO;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= ST_LO;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				case (step_q)
					ST_LO: begin
						step_q <= ST_HI;
					end
					ST_HI: begin
						step_q <= ST_CROSS;
					end
					ST_CROSS: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					default: begin
						busy_q <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
		end else if (busy_q) begin
			case (step_q)
				ST_LO: begin
					lo_q <= prod;
				end
				ST_HI: begin
					cross_q <= prod[31:0];
				end
				ST_CROSS: begin
					product_q <= {lo_q[63:32] + cross_q + prod[31:0], lo_q[31:0]};
				end
				default: begin
					lo_q <= lo_q;
				end
			endcase
		end
	end

	assign done    = done_q;
	assign product = product_q;

endmodule

/* sv/mm2h_dp.sv */
// Datapath: seed register, input latch, hash and mix registers, output register.
// Instantiates mm2h_mul; uses mm2h_pkg.
`timescale 1ns / 1ps

module mm2h_dp import mm2h_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_data,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        first_item,
	input  logic        last_item,
	input  logic [31:0] message_length,
	input  ctrl_cmd_t   cmd,
	output dp_stat_t    stat,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [63:0] hash_value
);

	logic [63:0] seed_q;
	logic [63:0] word_q;
	logic [3:0]  count_q;
	logic        first_q;
	logic        last_q;
	logic [31:0] len_q;
	logic [63:0] hash_q;
	logic [63:0] k_q;
	logic        out_valid_q;
	logic [63:0] hash_value_q;

	logic [31:0] len_in;
	logic [63:0] byte_mask;
	logic [63:0] fold_data;
	logic [63:0] mul_a;
	logic        mul_done;
	logic [63:0] mul_p;

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			len_in[i] = message_length[i] & (i < LENGTH_BITS);
		end
		for (int j = 0; j < 8; j++) begin
			byte_mask[8*j +: 8] = (count_q > 4'(j)) ? 8'hff : 8'h00;
		end
		fold_data = count_q[3] ? k_q : (word_q & byte_mask);
		case (cmd.mul_sel)
			MS_LEN:  mul_a = {32'd0, len_q};
			MS_WORD: mul_a = word_q;
			MS_K:    mul_a = k_q;
			MS_FOLD: mul_a = hash_q ^ fold_data;
			MS_FIN:  mul_a = hash_q ^ (hash_q >> MIX_SHIFT);
			default: mul_a = word_q;
		endcase
	end

	mm2h_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.done    (mul_done),
		.product (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= SEED_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_data;
			end
			if (mul_done && cmd.mul_sel == MS_FIN) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q  <= data_word;
			count_q <= byte_count;
			first_q <= first_item;
			last_q  <= last_item;
			len_q   <= len_in;
		end
		if (mul_done) begin
			case (cmd.mul_sel)
				MS_LEN:  hash_q       <= seed_q ^ mul_p;
				MS_WORD: k_q          <= mul_p ^ (mul_p >> MIX_SHIFT);
				MS_K:    k_q          <= mul_p;
				MS_FOLD: hash_q       <= mul_p;
				MS_FIN:  hash_value_q <= mul_p ^ (mul_p >> MIX_SHIFT);
				default: k_q          <= k_q;
			endcase
		end
	end

	assign stat = '{
		mul_done:   mul_done,
		first:      first_q,
		last:       last_q,
		count_full: count_q[3],
		count_zero: (count_q == 4'd0),
		out_busy:   out_valid_q
	};

	assign out_valid  = out_valid_q;
	assign hash_value = hash_value_q;

	// a finished hash never lands on a result still waiting
	a_fin_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done && cmd.mul_sel == MS_FIN) |-> !out_valid_q)
		else $error("final hash overwrote a pending result");

	// the result register holds while the output transfer is stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(hash_value_q)))
		else $error("pending result changed under stall");

endmodule

/* sv/mm2h_ctrl.sv */
// Controller: message state and sequencing of the shared multiplier.
// Drives mm2h_dp through ctrl_cmd_t and reads dp_stat_t; uses mm2h_pkg.
`timescale 1ns / 1ps

module mm2h_ctrl import mm2h_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output ctrl_cmd_t cmd,
	input  dp_stat_t  stat
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_DISPATCH,
		S_INIT,
		S_MIX1,
		S_MIX2,
		S_FOLD,
		S_HOLD,
		S_FIN
	} state_t;

	state_t   state_q;
	logic     in_msg_q;
	logic     start_q;
	mul_sel_t sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			in_msg_q <= 1'b0;
			start_q  <= 1'b0;
			sel_q    <= MS_LEN;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					if (stat.first) begin
						in_msg_q <= 1'b1;
						start_q  <= 1'b1;
						sel_q    <= MS_LEN;
						state_q  <= S_INIT;
					end else if (in_msg_q) begin
						state_q <= S_DISPATCH;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DISPATCH: begin
					if (stat.count_full) begin
						start_q <= 1'b1;
						sel_q   <= MS_WORD;
						state_q <= S_MIX1;
					end else if (!stat.count_zero) begin
						start_q <= 1'b1;
						sel_q   <= MS_FOLD;
						state_q <= S_FOLD;
					end else if (stat.last) begin
						state_q <= S_HOLD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_INIT: begin
					if (stat.mul_done) begin
						state_q <= S_DISPATCH;
					end
				end
				S_MIX1: begin
					if (stat.mul_done) begin
						start_q <= 1'b1;
						sel_q   <= MS_K;
						state_q <= S_MIX2;
					end
				end
				S_MIX2: begin
					if (stat.mul_done) begin
						start_q <= 1'b1;
						sel_q   <= MS_FOLD;
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					if (stat.mul_done) begin
						state_q <= stat.last ? S_HOLD : S_IDLE;
					end
				end
				S_HOLD: begin
					if (!stat.out_busy) begin
						in_msg_q <= 1'b0;
						start_q  <= 1'b1;
						sel_q    <= MS_FIN;
						state_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (stat.mul_done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign cmd = '{
		load:      in_valid && (state_q == S_IDLE),
		mul_start: start_q,
		mul_sel:   sel_q
	};

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.mul_done |-> (state_q == S_INIT || state_q == S_MIX1 || state_q == S_MIX2
			|| state_q == S_FOLD || state_q == S_FIN))
		else $error("multiply finished outside a wait state");

	a_start_gap: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> (!stat.mul_done && !start_q))
		else $error("multiply restarted or finished too early");

	a_fin_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> !in_msg_q)
		else $error("message still open during finalization");

endmodule

/* sv/murmur2_64_hash.sv */
// MurmurHash64A over a word stream: one item per transfer, one hash per message.
// Each 64-bit multiply runs on the shared multiplier; an item stalls the input while its
// multiplies run (0 to 5, the final mix of a last item among them); items outside a message are ignored.
// The hash becomes valid once the final mix multiply of the last item is done.
// The result waits in an output register; a new item is taken while it is pending.
// Reset clears the controller, the open-message flag and the output valid; seed returns to default.
`timescale 1ns / 1ps

module murmur2_64_hash import mm2h_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        first_item,
	input  logic        last_item,
	input  logic [31:0] message_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	mm2h_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	mm2h_dp #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.data_word      (data_word),
		.byte_count     (byte_count),
		.first_item     (first_item),
		.last_item      (last_item),
		.message_length (message_length),
		.cmd            (cmd),
		.stat           (stat),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.hash_value     (hash_value)
	);

endmodule
